// ----- design/lbp_pkg.sv -----
// Package for the loop branch predictor.
// Holds the beat widths, action codes and entry mode type; no dependencies.
package lbp_pkg;

   localparam int PC_WIDTH       = 32;
   localparam int CNT_OUT_WIDTH  = 16;
   localparam int REQ_DATA_WIDTH = 40;
   localparam int RSP_DATA_WIDTH = 24;

   localparam logic ACT_PREDICT = 1'b0;
   localparam logic ACT_UPDATE  = 1'b1;

   typedef enum logic [1:0] {
      MODE_INVALID  = 2'd0,
      MODE_TRAINING = 2'd1,
      MODE_LOCKED   = 2'd2
   } mode_type;

endpackage

// ----- design/lbp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/loop_branch_predictor_top.sv -----
// Loop branch predictor top level: entry table in lbp_ram, lookup and training logic.
// Depends on lbp_pkg and lbp_ram.
//
// Direct-mapped loop predictor with ENTRIES entries (a power of two) selected by
// branch_pc[2 +: log2(ENTRIES)]. One beat is accepted per cycle while the response
// register drains; each beat reads its entry from the table RAM, then the lookup stage
// computes and writes the entry back and loads the response register once that is free.
// Back-to-back beats to the same entry are forwarded around the table. After reset
// the table is cleared one entry a cycle, with req_tready low.
module loop_branch_predictor_top #(
   parameter int ENTRIES    = 256,
   parameter int COUNT_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [31:0] branch_pc, [32] taken, [33] was_predicted_taken, [39:34] zero
   input  logic [lbp_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // [0] action
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] predicted_taken, [16:1] iteration_count, [23:17] zero
   output logic [lbp_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // [0] hit
   output logic                               rsp_tuser
);
   import lbp_pkg::*;

   localparam int IDX_BITS = $clog2(ENTRIES);

   typedef struct packed {
      logic [PC_WIDTH-1:0]   tag;
      mode_type              mode;
      logic [COUNT_BITS-1:0] limit;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   localparam int ENTRY_WIDTH = $bits(entry_type);

   logic                  clearing_ff;
   logic [IDX_BITS-1:0]   clr_idx_ff;

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_action_ff;
   logic [PC_WIDTH-1:0]   s1_pc_ff;
   logic                  s1_taken_ff;
   logic                  s1_wpt_ff;
   logic                  fwd_hit_ff;
   entry_type             fwd_data_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff;
   logic                  rsp_pt_ff;
   logic [CNT_OUT_WIDTH-1:0] rsp_cnt_ff;

   logic                  accept;
   logic                  s1_advance;
   logic [PC_WIDTH-1:0]   req_pc;
   logic [IDX_BITS-1:0]   req_idx;
   logic [IDX_BITS-1:0]   s1_idx;

   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [ENTRY_WIDTH-1:0] wr_data;
   logic [ENTRY_WIDTH-1:0] rd_data;

   entry_type             cur;
   entry_type             upd;
   entry_type             nxt;
   logic                  tag_match;
   logic                  hit;
   logic                  pred_taken;
   logic [31:0]           cnt_wide;

   assign req_pc     = req_tdata[PC_WIDTH-1:0];
   assign req_idx    = req_pc[2 +: IDX_BITS];
   assign s1_idx     = s1_pc_ff[2 +: IDX_BITS];
   assign s1_advance = !rsp_valid_ff || rsp_tready;
   assign req_tready = !clearing_ff && (!s1_valid_ff || s1_advance);
   assign accept     = req_tvalid && req_tready;

   lbp_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (req_idx),
      .rd_data (rd_data)
   );

   // entry lookup and training
   always_comb begin
      cur        = fwd_hit_ff ? fwd_data_ff : entry_type'(rd_data);
      tag_match  = (cur.tag == s1_pc_ff);
      hit        = 1'b0;
      pred_taken = 1'b0;
      nxt        = cur;
      upd        = tag_match ? cur : '0;
      if (s1_action_ff == ACT_PREDICT) begin
         hit = tag_match && (cur.mode == MODE_LOCKED);
         if (hit) begin
            if (cur.count == cur.limit) begin
               nxt.count = '0;
            end else begin
               pred_taken = 1'b1;
               nxt.count  = cur.count + COUNT_BITS'(1);
            end
         end
      end else begin
         nxt = upd;
         case (upd.mode)
            MODE_INVALID: begin
               nxt.tag   = s1_pc_ff;
               nxt.mode  = MODE_TRAINING;
               nxt.limit = COUNT_BITS'(1);
               nxt.count = '0;
            end
            MODE_TRAINING: begin
               if (!s1_taken_ff) begin
                  nxt.mode = MODE_LOCKED;
               end else if (upd.limit != '1) begin
                  nxt.limit = upd.limit + COUNT_BITS'(1);
               end
            end
            MODE_LOCKED: begin
               if (s1_taken_ff != s1_wpt_ff) begin
                  nxt.mode = MODE_INVALID;
               end
            end
            default: begin
            end
         endcase
      end
      cnt_wide = 32'(cur.count);
   end

   always_comb begin
      if (clearing_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_idx_ff;
         wr_data = '0;
      end else begin
         wr_en   = s1_valid_ff && s1_advance;
         wr_addr = s1_idx;
         wr_data = nxt;
      end
   end

   assign s1_valid_in = accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_idx_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_idx_ff <= clr_idx_ff + IDX_BITS'(1);
            if (clr_idx_ff == IDX_BITS'(ENTRIES - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         s1_valid_ff <= s1_valid_in;
         if (s1_valid_ff && s1_advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff <= req_tuser;
         s1_pc_ff     <= req_pc;
         s1_taken_ff  <= req_tdata[PC_WIDTH];
         s1_wpt_ff    <= req_tdata[PC_WIDTH+1];
         fwd_hit_ff   <= wr_en && (wr_addr == req_idx);
         fwd_data_ff  <= entry_type'(wr_data);
      end
      if (s1_valid_ff && s1_advance) begin
         rsp_hit_ff <= hit;
         rsp_pt_ff  <= pred_taken;
         rsp_cnt_ff <= hit ? cnt_wide[CNT_OUT_WIDTH-1:0] : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - CNT_OUT_WIDTH - 1){1'b0}}, rsp_cnt_ff, rsp_pt_ff};

   a_no_beat_while_clearing : assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !rsp_tvalid && !s1_valid_ff)
      else $error("beat in flight during table clear");

   a_update_never_hits : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_advance && (s1_action_ff == ACT_UPDATE) |=> !rsp_tuser)
      else $error("update beat reported a hit");

   a_miss_is_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss response carries nonzero fields");

   a_stall_holds_stage : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(s1_pc_ff))
      else $error("stalled stage lost its beat");

endmodule

// ----- test/tb_loop_branch_predictor_top.sv -----
// Testbench for loop_branch_predictor_top: drives lookup and update beats and checks
// each response against an in-bench copy of the loop table. Depends on lbp_pkg and
// the predictor RTL.
`timescale 1ns / 1ps

module tb_loop_branch_predictor_top;
   import lbp_pkg::*;

   localparam int ENTRIES     = 256;
   localparam int SLOT_BITS   = 8;
   localparam int CYCLE_LIMIT = 60000;
   localparam int RANDOM_BEATS_PER_PHASE = 380;

   typedef struct packed {
      logic        hit;
      logic        predicted_taken;
      logic [15:0] iteration_count;
   } loop_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic rsp_tuser;

   logic [31:0] tag_table   [ENTRIES];
   mode_type    mode_table  [ENTRIES];
   logic [15:0] limit_table [ENTRIES];
   logic [15:0] count_table [ENTRIES];

   loop_result_type predictions_due[$];
   logic [31:0]  branch_pool[8];
   int error_count   = 0;
   int cycle_count   = 0;
   int beats_sent    = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_left     = 0;
   logic hold_req    = 1'b0;

   loop_branch_predictor_top #(
      .ENTRIES   (ENTRIES),
      .COUNT_BITS(16)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always #2 clock = ~clock;

   initial begin
      for (int i = 0; i < ENTRIES; i++) begin
         tag_table[i]   = '0;
         mode_table[i]  = MODE_INVALID;
         limit_table[i] = '0;
         count_table[i] = '0;
      end
   end

   function automatic loop_result_type advance_loop_table(input logic action,
                                                          input logic [31:0] pc,
                                                          input logic tk,
                                                          input logic wpt);
      loop_result_type r;
      logic [SLOT_BITS-1:0] s;
      r = '0;
      s = pc[2 +: SLOT_BITS];
      if (action == ACT_PREDICT) begin
         if (tag_table[s] == pc && mode_table[s] == MODE_LOCKED) begin
            r.hit = 1'b1;
            r.iteration_count = count_table[s];
            if (count_table[s] == limit_table[s]) begin
               count_table[s] = '0;
            end else begin
               r.predicted_taken = 1'b1;
               count_table[s] = count_table[s] + 16'd1;
            end
         end
      end else begin
         if (tag_table[s] != pc) begin
            tag_table[s]   = '0;
            mode_table[s]  = MODE_INVALID;
            limit_table[s] = '0;
            count_table[s] = '0;
         end
         case (mode_table[s])
            MODE_INVALID: begin
               tag_table[s]   = pc;
               mode_table[s]  = MODE_TRAINING;
               limit_table[s] = 16'd1;
               count_table[s] = '0;
            end
            MODE_TRAINING: begin
               if (!tk) begin
                  mode_table[s] = MODE_LOCKED;
               end else if (limit_table[s] != 16'hFFFF) begin
                  limit_table[s] = limit_table[s] + 16'd1;
               end
            end
            MODE_LOCKED: begin
               if (tk != wpt) begin
                  mode_table[s] = MODE_INVALID;
               end
            end
            default: begin
            end
         endcase
      end
      return r;
   endfunction

   // predict on accepted beats, check each response beat against the oldest prediction
   always @(posedge clock) begin
      loop_result_type due;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predictions_due.push_back(advance_loop_table(req_tuser, req_tdata[31:0],
                                                         req_tdata[32], req_tdata[33]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (predictions_due.size() == 0) begin
               $error("response beat with no pending request");
               error_count++;
            end else begin
               due = predictions_due.pop_front();
               if (rsp_tuser !== due.hit) begin
                  $error("hit: expected %0d, got %0d", due.hit, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[0] !== due.predicted_taken) begin
                  $error("predicted_taken: expected %0d, got %0d",
                         due.predicted_taken, rsp_tdata[0]);
                  error_count++;
               end
               if (rsp_tdata[16:1] !== due.iteration_count) begin
                  $error("iteration_count: expected %0d, got %0d",
                         due.iteration_count, rsp_tdata[16:1]);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_req) begin
         hold_left  <= 300;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_beat(input logic action, input logic [31:0] pc,
                            input logic tk, input logic wpt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {6'b0, wpt, tk, pc};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_lookup(input logic [31:0] pc);
      send_beat(ACT_PREDICT, pc, 1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   task automatic send_train(input logic [31:0] pc, input logic tk, input logic wpt);
      send_beat(ACT_UPDATE, pc, tk, wpt);
   endtask

   task automatic send_noise();
      logic [31:0] pc;
      pc = ($urandom_range(1) == 1) ? branch_pool[$urandom_range(7)] : $urandom;
      send_beat(1'($urandom_range(1)), pc, 1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   task automatic test_directed();
      send_lookup(32'h0000_0000);
      send_train(32'h0000_0000, 1'b1, 1'b0);
      send_lookup(32'h0000_0000);
      send_train(32'h0000_0000, 1'b1, 1'b1);
      send_train(32'h0000_0000, 1'b0, 1'b0);
      repeat (3) send_lookup(32'h0000_0000);
      send_train(32'h0000_0000, 1'b1, 1'b1);
      // alias the same slot with a different tag
      send_train(32'h8000_0000, 1'b1, 1'b1);
      send_lookup(32'h0000_0000);
      send_train(32'h8000_0000, 1'b0, 1'b0);
      send_lookup(32'h8000_0000);
      // mispredict drops the lock, then retrain on the kept tag
      send_train(32'h8000_0000, 1'b0, 1'b1);
      send_lookup(32'h8000_0000);
      send_train(32'h8000_0000, 1'b1, 1'b0);
      send_train(32'hFFFF_FFFC, 1'b0, 1'b1);
      send_train(32'hFFFF_FFFC, 1'b0, 1'b0);
      repeat (2) send_lookup(32'hFFFF_FFFC);
      send_train(32'hFFFF_FFFC, 1'b0, 1'b0);
      send_train(32'hFFFF_FFFC, 1'b1, 1'b1);
      send_lookup(32'hFFFF_FFFF);
      send_train(32'h5555_5556, 1'b1, 1'b0);
      send_lookup(32'hAAAA_AAA9);
   endtask

   // train a long trip count, then walk the count through it and back to zero
   task automatic test_long_trip();
      send_idle_pct = 0;
      stall_pct     = 0;
      for (int i = 0; i < 96; i++) send_train(32'hFFFF_FFFF, 1'b1, 1'b1);
      send_train(32'hFFFF_FFFF, 1'b0, 1'b0);
      for (int i = 0; i < 99; i++) send_lookup(32'hFFFF_FFFF);
   endtask

   task automatic run_loop_sequence(input logic [31:0] pc);
      int trips;
      int passes;
      logic tk;
      trips  = $urandom_range(1, 6);
      passes = $urandom_range(1, 3);
      for (int i = 0; i < trips; i++) send_train(pc, 1'b1, 1'b1);
      send_train(pc, 1'b0, 1'b0);
      for (int p = 0; p < passes; p++) begin
         for (int i = 0; i <= trips; i++) begin
            tk = (i < trips);
            send_lookup(pc);
            send_train(pc, tk, ($urandom_range(99) < 92) ? tk : !tk);
            if ($urandom_range(99) < 15) send_noise();
         end
      end
   endtask

   task automatic run_random_phase(input int idle, input int stall);
      int target;
      send_idle_pct = idle;
      stall_pct     = stall;
      target = beats_sent + RANDOM_BEATS_PER_PHASE;
      while (beats_sent < target) begin
         if ($urandom_range(99) < 75) begin
            run_loop_sequence(branch_pool[$urandom_range(7)]);
         end else begin
            send_noise();
         end
      end
   endtask

   task automatic test_random_traffic();
      for (int i = 0; i < 4; i++) begin
         branch_pool[i]     = $urandom;
         branch_pool[i + 4] = {~branch_pool[i][31:10], branch_pool[i][9:0]};
      end
      run_random_phase(0, 0);
      run_random_phase(86, 0);
      run_random_phase(0, 86);
      run_random_phase(38, 38);
   endtask

   // block responses for a long stretch while requests keep coming
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_req <= 1'b1;
      @(posedge clock);
      hold_req <= 1'b0;
      for (int i = 0; i < 60; i++) send_noise();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_long_trip();
      test_random_traffic();
      test_backpressure();
      req_tvalid <= 1'b0;
      while (predictions_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (predictions_due.size() != 0) begin
         $error("%0d responses never arrived", predictions_due.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
